// ===== hw/rtl/steer_torque_split_power_limit_assert.svh =====
// Assertion macros for the torque split RTL.
`ifndef STEER_TORQUE_SPLIT_POWER_LIMIT_ASSERT_SVH
`define STEER_TORQUE_SPLIT_POWER_LIMIT_ASSERT_SVH
`ifndef SYNTHESIS
`define STSPLIT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define STSPLIT_ASSERT_NR(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define STSPLIT_ASSERT(name, prop, msg)
`define STSPLIT_ASSERT_NR(name, prop, msg)
`endif
`endif

// ===== hw/rtl/stsplit_pkg.sv =====
// Constants, register codes and tan tables for the torque split datapath.
package stsplit_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRACK     = 2'd0,
    REG_WHEELBASE = 2'd1,
    REG_FACTOR    = 2'd2,
    REG_EPS       = 2'd3
  } cfg_reg_e;

  localparam logic [11:0] TRACK_RST  = 12'd1200;
  localparam logic [11:0] WB_RST     = 12'd1550;
  localparam logic [15:0] FACTOR_RST = 16'd9549;
  localparam logic [9:0]  EPS_RST    = 10'd1;

  // Divider geometry: numerator, denominator, quotient bits, sideband.
  localparam int DIV_NW   = 56;
  localparam int DIV_DW   = 40;
  localparam int DIV_QW   = 21;
  localparam int DIV_CW   = DIV_DW + DIV_QW;
  localparam int DIV_SB_W = 96;

  // floor(2^32 / 500) for the interpolation divide
  localparam logic [23:0] RECIP_500 = 24'd8589934;

  function automatic logic [16:0] tan_base(input logic [3:0] idx);
    logic [16:0] v;
    case (idx)
      4'd0: v = 17'd0;
      4'd1: v = 17'd5734;
      4'd2: v = 17'd11556;
      4'd3: v = 17'd17560;
      4'd4: v = 17'd23853;
      4'd5: v = 17'd30560;
      4'd6: v = 17'd37837;
      4'd7: v = 17'd45889;
      4'd8: v = 17'd54992;
      4'd9: v = 17'd65536;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  function automatic logic [13:0] tan_step(input logic [3:0] idx);
    logic [13:0] v;
    case (idx)
      4'd0: v = 14'd5734;
      4'd1: v = 14'd5822;
      4'd2: v = 14'd6004;
      4'd3: v = 14'd6293;
      4'd4: v = 14'd6707;
      4'd5: v = 14'd7277;
      4'd6: v = 14'd8052;
      4'd7: v = 14'd9103;
      4'd8: v = 14'd10544;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

  function automatic logic [12:0] seg_start(input logic [3:0] idx);
    logic [12:0] v;
    case (idx)
      4'd0: v = 13'd0;
      4'd1: v = 13'd500;
      4'd2: v = 13'd1000;
      4'd3: v = 13'd1500;
      4'd4: v = 13'd2000;
      4'd5: v = 13'd2500;
      4'd6: v = 13'd3000;
      4'd7: v = 13'd3500;
      4'd8: v = 13'd4000;
      4'd9: v = 13'd4500;
      default: v = 13'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/stsplit_if.sv =====
// Handshake channels: item input, result output and register write.
interface stsplit_in_if;
  logic               valid;
  logic               ready;
  logic signed [13:0] steer_angle;
  logic               regen_mode;
  logic [13:0]        power_limit;
  logic signed [15:0] speed_front_left;
  logic signed [15:0] speed_front_right;
  logic signed [15:0] speed_rear_left;
  logic signed [15:0] speed_rear_right;
  logic signed [15:0] torque_request;
  logic signed [16:0] derate_factor;

  modport source (output valid, steer_angle, regen_mode, power_limit, speed_front_left,
                  speed_front_right, speed_rear_left, speed_rear_right, torque_request,
                  derate_factor, input ready);
  modport sink (input valid, steer_angle, regen_mode, power_limit, speed_front_left,
                speed_front_right, speed_rear_left, speed_rear_right, torque_request,
                derate_factor, output ready);
endinterface

interface stsplit_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] torque_front_left;
  logic signed [16:0] torque_front_right;
  logic signed [16:0] torque_rear_left;
  logic signed [16:0] torque_rear_right;

  modport source (output valid, torque_front_left, torque_front_right, torque_rear_left,
                  torque_rear_right, input ready);
  modport sink (input valid, torque_front_left, torque_front_right, torque_rear_left,
                torque_rear_right, output ready);
endinterface

interface stsplit_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/steer_torque_split_power_limit.sv =====
// Top level of the four-motor torque split with steering gain and power limit.
// Fully pipelined: one item is accepted every clock while the pipe is not frozen,
// and its four wheel torques pass through 5 stages of angle and tan interpolation,
// three 22-stage restoring dividers for the yaw ratio, the torque limit and the
// scale, and 10 further multiply, compare and rounding stages. The whole
// pipe advances together and freezes only while the output register holds a
// beat the sink has not taken; items in flight are never dropped or doubled.
// Registers are written through the config channel, which is always ready;
// write them only while no item is in flight. The left wheels share one
// command and the right wheels another.
`include "steer_torque_split_power_limit_assert.svh"

module steer_torque_split_power_limit (
  input  logic   clk_i,
  input  logic   rst_ni,
  stsplit_cfg_if.sink   cfg_i,
  stsplit_in_if.sink    item_i,
  stsplit_out_if.source res_o
);
  import stsplit_pkg::*;

  // item context carried through the front end and the first divider
  typedef struct packed {
    logic               aneg;
    logic               regen;
    logic [13:0]        pwr;
    logic signed [16:0] suml;
    logic signed [16:0] sumr;
    logic signed [15:0] req;
    logic signed [16:0] der;
  } ctx_t;

  typedef struct packed {
    logic               regen;
    logic signed [16:0] der;
    logic signed [34:0] tl;
    logic signed [34:0] tr;
    logic               den_zero;
    logic               num_pos;
    logic               den_neg;
  } sb2_t;

  typedef struct packed {
    logic               use_div;
    logic               qneg;
    logic               dsr_zero;
    logic               dvd_neg;
    logic               dvd_zero;
    logic [15:0]        scale0;
    logic signed [34:0] tl;
    logic signed [34:0] tr;
  } sb3_t;

  localparam int CTX_W = $bits(ctx_t);
  localparam int SB2_W = $bits(sb2_t);
  localparam int SB3_W = $bits(sb3_t);

  localparam logic [20:0] SAT_Q = 21'd1048576;

  // configuration registers
  logic [11:0] track_q, wb_q;
  logic [15:0] factor_q;
  logic [9:0]  eps_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_q  <= TRACK_RST;
      wb_q     <= WB_RST;
      factor_q <= FACTOR_RST;
      eps_q    <= EPS_RST;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_TRACK:     track_q  <= cfg_i.data[11:0];
        REG_WHEELBASE: wb_q     <= cfg_i.data[11:0];
        REG_FACTOR:    factor_q <= cfg_i.data;
        REG_EPS:       eps_q    <= cfg_i.data[9:0];
        default: ;
      endcase
    end
  end

  // advance everything whenever the output register is free or being taken
  logic en;
  logic out_vld_q;
  assign en           = !out_vld_q || res_o.ready;
  assign item_i.ready = en;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q;
  logic v10_q, v11_q, v12_q, v13_q, v14_q;
  logic vd1, vd2, vd3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q} <= '0;
      {v8_q, v9_q, v10_q, v11_q, v12_q, v13_q, v14_q} <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      v1_q      <= item_i.valid;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      v5_q      <= v4_q;
      v6_q      <= vd1;
      v7_q      <= v6_q;
      v8_q      <= v7_q;
      v9_q      <= v8_q;
      v10_q     <= vd2;
      v11_q     <= v10_q;
      v12_q     <= v11_q;
      v13_q     <= vd3;
      v14_q     <= v13_q;
      out_vld_q <= v14_q;
    end
  end

  // ---- stage 1: angle magnitude, tan segment, side speed sums
  logic [13:0] amag;
  logic [12:0] am;
  logic [3:0]  idx;
  ctx_t        c1_d;

  always_comb begin
    amag = item_i.steer_angle[13] ? 14'(-item_i.steer_angle) : 14'(item_i.steer_angle);
    am   = (amag > 14'd4500) ? 13'd4500 : amag[12:0];
    idx  = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (am >= 13'(k * 500)) idx = 4'(k);
    end
    c1_d.aneg  = item_i.steer_angle[13];
    c1_d.regen = item_i.regen_mode;
    c1_d.pwr   = item_i.power_limit;
    c1_d.suml  = 17'(item_i.speed_front_left) + 17'(item_i.speed_rear_left);
    c1_d.sumr  = 17'(item_i.speed_front_right) + 17'(item_i.speed_rear_right);
    c1_d.req   = item_i.torque_request;
    c1_d.der   = item_i.derate_factor;
  end

  ctx_t        c1_q, c2_q, c3_q, c4_q, c5_q;
  logic [3:0]  idx1_q;
  logic [8:0]  frac1_q;
  logic [23:0] x2_q, x3_q;
  logic [16:0] tb2_q, tb3_q, t4_q;
  logic [15:0] q03_q;
  logic [28:0] prod5_q;
  logic [12:0] den5_q;

  // ---- stages 2-5: interpolate tan, divide the step by 500, scale by track
  logic [47:0] p3;
  logic [23:0] r4;
  logic [15:0] q4;
  assign p3 = 48'(x2_q) * 48'(RECIP_500);
  assign r4 = x3_q - 24'(q03_q) * 24'd500;
  assign q4 = (r4 >= 24'd500) ? q03_q + 16'd1 : q03_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q    <= c1_d;
      idx1_q  <= idx;
      frac1_q <= 9'(am - seg_start(idx));
      c2_q    <= c1_q;
      x2_q    <= 24'(tan_step(idx1_q)) * 24'(frac1_q) + 24'd250;
      tb2_q   <= tan_base(idx1_q);
      c3_q    <= c2_q;
      x3_q    <= x2_q;
      tb3_q   <= tb2_q;
      q03_q   <= p3[47:32];
      c4_q    <= c3_q;
      t4_q    <= tb3_q + 17'(q4);
      c5_q    <= c4_q;
      prod5_q <= 29'(track_q) * 29'(t4_q);
      den5_q  <= (wb_q == 12'd0) ? 13'd2 : {wb_q, 1'b0};
    end
  end

  // ---- divider 1: yaw ratio magnitude
  logic [DIV_QW-1:0]   quo1, quo2, quo3;
  logic                ovf1, ovf2, ovf3;
  logic [DIV_SB_W-1:0] sbo1, sbo2, sbo3;

  stsplit_div u_div_delta (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v5_q),
    .num_i   (DIV_NW'(prod5_q)),
    .den_i   (DIV_DW'(den5_q)),
    .side_i  (DIV_SB_W'(c5_q)),
    .valid_o (vd1),
    .quo_o   (quo1),
    .ovf_o   (ovf1),
    .side_o  (sbo1)
  );

  // ---- stage 6: side gains, swapped in regen
  ctx_t               cd1;
  logic [16:0]        dm;
  logic signed [17:0] d6;
  logic signed [18:0] cl_d, cr_d;
  assign cd1 = ctx_t'(sbo1[CTX_W-1:0]);

  always_comb begin
    dm   = (ovf1 || quo1 > 21'd131071) ? 17'd131071 : quo1[16:0];
    d6   = cd1.aneg ? -$signed({1'b0, dm}) : $signed({1'b0, dm});
    cl_d = cd1.regen ? 19'sd65536 - 19'(d6) : 19'sd65536 + 19'(d6);
    cr_d = cd1.regen ? 19'sd65536 + 19'(d6) : 19'sd65536 - 19'(d6);
  end

  ctx_t               c6_q;
  logic signed [18:0] cl6_q, cr6_q;
  logic signed [35:0] pl7_q, pr7_q;
  logic signed [34:0] tl7_q, tr7_q, tl8_q, tr8_q;
  logic [29:0]        num7_q, num8_q, num9_q;
  logic               regen7_q, regen8_q;
  logic signed [16:0] der7_q, der8_q;
  logic signed [37:0] den8_q;
  logic [DIV_DW-1:0]  dmag9_q;
  sb2_t               sb9_q;

  // ---- stages 6-9: side torques, limit denominator and its magnitude
  always_ff @(posedge clk_i) begin
    if (en) begin
      c6_q     <= cd1;
      cl6_q    <= cl_d;
      cr6_q    <= cr_d;
      pl7_q    <= 36'(c6_q.suml) * 36'(cl6_q);
      pr7_q    <= 36'(c6_q.sumr) * 36'(cr6_q);
      tl7_q    <= 35'(c6_q.req) * 35'(cl6_q);
      tr7_q    <= 35'(c6_q.req) * 35'(cr6_q);
      num7_q   <= 30'(factor_q) * 30'(c6_q.pwr);
      regen7_q <= c6_q.regen;
      der7_q   <= c6_q.der;
      den8_q   <= 38'(pl7_q) + 38'(pr7_q) + $signed({12'b0, eps_q, 16'b0});
      num8_q   <= num7_q;
      tl8_q    <= tl7_q;
      tr8_q    <= tr7_q;
      regen8_q <= regen7_q;
      der8_q   <= der7_q;
      dmag9_q  <= den8_q[37] ? 40'(-den8_q) : 40'(den8_q);
      num9_q   <= num8_q;
      sb9_q.regen    <= regen8_q;
      sb9_q.der      <= der8_q;
      sb9_q.tl       <= tl8_q;
      sb9_q.tr       <= tr8_q;
      sb9_q.den_zero <= (den8_q == 38'sd0);
      sb9_q.num_pos  <= (num8_q != 30'd0);
      sb9_q.den_neg  <= den8_q[37];
    end
  end

  // ---- divider 2: torque limit
  stsplit_div u_div_limit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v9_q),
    .num_i   (DIV_NW'({num9_q, 16'b0})),
    .den_i   (dmag9_q),
    .side_i  (DIV_SB_W'(sb9_q)),
    .valid_o (vd2),
    .quo_o   (quo2),
    .ovf_o   (ovf2),
    .side_o  (sbo2)
  );

  // ---- stage 10: signed limit, larger and smaller side torque
  sb2_t               s2;
  logic [20:0]        lmag;
  logic signed [21:0] lim_d;
  assign s2 = sb2_t'(sbo2[SB2_W-1:0]);

  always_comb begin
    lmag = (ovf2 || quo2 > SAT_Q) ? SAT_Q : quo2;
    if (s2.den_zero) begin
      lim_d = s2.num_pos ? $signed({1'b0, SAT_Q}) : 22'sd0;
    end else begin
      lim_d = s2.den_neg ? -$signed({1'b0, lmag}) : $signed({1'b0, lmag});
    end
  end

  logic signed [21:0] lim10_q;
  logic signed [34:0] mx10_q, mn10_q, tl10_q, tr10_q;
  logic               regen10_q;
  logic signed [16:0] der10_q;

  // ---- stage 11: limit test and scale dividend
  logic signed [37:0] limq;
  logic [15:0]        scale0;
  logic               use_d;
  logic signed [54:0] dvd_d;
  assign limq = $signed({lim10_q, 16'b0});

  always_comb begin
    if (der10_q < 17'sd0) begin
      scale0 = 16'd0;
    end else if (der10_q > 17'sd32768) begin
      scale0 = 16'd32768;
    end else begin
      scale0 = der10_q[15:0];
    end
    if (regen10_q) begin
      use_d = 39'(mn10_q) < -39'(limq);
      dvd_d = 55'($signed({1'b0, scale0})) * (-55'(limq));
    end else begin
      use_d = 39'(mx10_q) > 39'(limq);
      dvd_d = 55'($signed({limq, 15'b0}));
    end
  end

  logic               use11_q;
  logic signed [54:0] dvd11_q;
  logic signed [34:0] dsr11_q, tl11_q, tr11_q;
  logic [15:0]        scale011_q;
  logic [DIV_NW-1:0]  dvdmag12_q;
  logic [DIV_DW-1:0]  dsrmag12_q;
  sb3_t               sb12_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      lim10_q    <= lim_d;
      mx10_q     <= (s2.tl > s2.tr) ? s2.tl : s2.tr;
      mn10_q     <= (s2.tl < s2.tr) ? s2.tl : s2.tr;
      tl10_q     <= s2.tl;
      tr10_q     <= s2.tr;
      regen10_q  <= s2.regen;
      der10_q    <= s2.der;
      use11_q    <= use_d;
      dvd11_q    <= dvd_d;
      dsr11_q    <= regen10_q ? mn10_q : mx10_q;
      scale011_q <= scale0;
      tl11_q     <= tl10_q;
      tr11_q     <= tr10_q;
      // stage 12: magnitudes and sign of the scale quotient
      dvdmag12_q      <= dvd11_q[54] ? 56'(-dvd11_q) : 56'(dvd11_q);
      dsrmag12_q      <= dsr11_q[34] ? 40'(-dsr11_q) : 40'(dsr11_q);
      sb12_q.use_div  <= use11_q;
      sb12_q.qneg     <= dvd11_q[54] ^ dsr11_q[34];
      sb12_q.dsr_zero <= (dsr11_q == 35'sd0);
      sb12_q.dvd_neg  <= dvd11_q[54];
      sb12_q.dvd_zero <= (dvd11_q == 55'sd0);
      sb12_q.scale0   <= scale011_q;
      sb12_q.tl       <= tl11_q;
      sb12_q.tr       <= tr11_q;
    end
  end

  // ---- divider 3: replacement scale
  stsplit_div u_div_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v12_q),
    .num_i   (dvdmag12_q),
    .den_i   (dsrmag12_q),
    .side_i  (DIV_SB_W'(sb12_q)),
    .valid_o (vd3),
    .quo_o   (quo3),
    .ovf_o   (ovf3),
    .side_o  (sbo3)
  );

  // ---- stage 13: final scale
  sb3_t               s3;
  logic [20:0]        smag;
  logic signed [21:0] scale_d;
  assign s3 = sb3_t'(sbo3[SB3_W-1:0]);

  always_comb begin
    smag = (ovf3 || quo3 > SAT_Q) ? SAT_Q : quo3;
    if (!s3.use_div) begin
      scale_d = $signed({6'b0, s3.scale0});
    end else if (s3.dsr_zero) begin
      if (s3.dvd_zero) begin
        scale_d = 22'sd0;
      end else begin
        scale_d = s3.dvd_neg ? -$signed({1'b0, SAT_Q}) : $signed({1'b0, SAT_Q});
      end
    end else begin
      scale_d = s3.qneg ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
    end
  end

  // round half away from zero by 2^31, saturate to the 17 bit output range
  function automatic logic signed [16:0] round_out(input logic signed [56:0] p);
    logic [56:0] m;
    logic [26:0] r;
    logic [16:0] v;
    m = p[56] ? 57'(-p) : 57'(p);
    r = 27'((m + 57'd1073741824) >> 31);
    if (p[56]) begin
      v = (r > 27'd65536) ? 17'h10000 : 17'(-r);
    end else begin
      v = (r > 27'd65535) ? 17'h0FFFF : r[16:0];
    end
    return $signed(v);
  endfunction

  logic signed [21:0] scale13_q;
  logic signed [34:0] tl13_q, tr13_q;
  logic signed [56:0] pl14_q, pr14_q;
  logic signed [16:0] tq_l_q, tq_r_q;

  // ---- stages 13-15: apply scale, round into the output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      scale13_q <= scale_d;
      tl13_q    <= s3.tl;
      tr13_q    <= s3.tr;
      pl14_q    <= 57'(tl13_q) * 57'(scale13_q);
      pr14_q    <= 57'(tr13_q) * 57'(scale13_q);
      tq_l_q    <= round_out(pl14_q);
      tq_r_q    <= round_out(pr14_q);
    end
  end

  assign res_o.valid              = out_vld_q;
  assign res_o.torque_front_left  = tq_l_q;
  assign res_o.torque_rear_left   = tq_l_q;
  assign res_o.torque_front_right = tq_r_q;
  assign res_o.torque_rear_right  = tq_r_q;

  `STSPLIT_ASSERT(a_gain_pair, v6_q |-> (cl6_q + cr6_q) == 19'sd131072, "side gains do not sum to two")
  `STSPLIT_ASSERT(a_stall_hold, !en |=> $stable({v1_q, v5_q, v9_q, v12_q, v14_q, out_vld_q}), "pipe moved while stalled")
  `STSPLIT_ASSERT(a_scale_range, v13_q |-> (scale13_q <= 22'sd1048576) && (scale13_q >= -22'sd1048576), "scale beyond saturation")
  `STSPLIT_ASSERT(a_out_src, $rose(out_vld_q) |-> $past(v14_q), "result beat without a live item")
  `STSPLIT_ASSERT_NR(a_rst_empty, !rst_ni |-> !out_vld_q, "result valid during reset")

endmodule

// ===== hw/rtl/stsplit_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module stsplit_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [stsplit_pkg::DIV_NW-1:0]   num_i,
  input  logic [stsplit_pkg::DIV_DW-1:0]   den_i,
  input  logic [stsplit_pkg::DIV_SB_W-1:0] side_i,
  output logic                             valid_o,
  output logic [stsplit_pkg::DIV_QW-1:0]   quo_o,
  output logic                             ovf_o,
  output logic [stsplit_pkg::DIV_SB_W-1:0] side_o
);
  import stsplit_pkg::*;

  logic [DIV_QW:0]       vld_q;
  logic                  ovf_q  [DIV_QW+1];
  logic [DIV_NW-1:0]     rem_q  [DIV_QW+1];
  logic [DIV_DW-1:0]     den_q  [DIV_QW+1];
  logic [DIV_QW-1:0]     quo_q  [DIV_QW+1];
  logic [DIV_SB_W-1:0]   sb_q   [DIV_QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DIV_QW-1:0], valid_i};
    end
  end

  // quotient that does not fit in DIV_QW bits is flagged up front
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= DIV_CW'(num_i) >= (DIV_CW'(den_i) << DIV_QW);
      sb_q[0]  <= side_i;
    end
  end

  for (genvar j = 1; j <= DIV_QW; j++) begin : g_bit
    localparam int B = DIV_QW - j;
    logic [DIV_CW-1:0] remx;
    logic [DIV_CW-1:0] dsh;
    logic              ge;

    assign remx = DIV_CW'(rem_q[j-1]);
    assign dsh  = DIV_CW'(den_q[j-1]) << B;
    assign ge   = remx >= dsh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? DIV_NW'(remx - dsh) : rem_q[j-1];
        quo_q[j] <= quo_q[j-1] | (ge ? (DIV_QW'(1) << B) : '0);
        den_q[j] <= den_q[j-1];
        ovf_q[j] <= ovf_q[j-1];
        sb_q[j]  <= sb_q[j-1];
      end
    end
  end

  assign valid_o = vld_q[DIV_QW];
  assign quo_o   = quo_q[DIV_QW];
  assign ovf_o   = ovf_q[DIV_QW];
  assign side_o  = sb_q[DIV_QW];

endmodule
